FILE: hw/rtl/tvs_pkg.sv
package tvs_pkg;

    localparam int MaxLen = 64;
    localparam int IdxW   = $clog2(MaxLen);
    localparam int CntW   = $clog2(MaxLen + 1);

    typedef enum logic [1:0] {
        TYPE_BOOL   = 2'd0,
        TYPE_PIXEL  = 2'd1,
        TYPE_INT32  = 2'd2,
        TYPE_DOUBLE = 2'd3
    } t_elem_type;

    typedef struct packed {
        logic [63:0] element_value;
        logic        is_final;
    } t_in_item;

    typedef struct packed {
        logic [63:0] sorted_value;
        logic        end_of_run;
        logic        overflowed;
    } t_out_item;

    function automatic logic [63:0] norm_value(logic [63:0] raw, t_elem_type ty);
        logic [63:0] v;
        case (ty)
            TYPE_BOOL:  v = {63'd0, |raw};
            TYPE_PIXEL: v = {56'd0, raw[7:0]};
            TYPE_INT32: v = {32'd0, raw[31:0]};
            default:    v = raw;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] order_key(logic [63:0] v, t_elem_type ty);
        logic [63:0] k;
        case (ty)
            TYPE_INT32:  k = {32'd0, v[31:0] ^ 32'h8000_0000};
            TYPE_DOUBLE: k = v[63] ? ~v : {1'b1, v[62:0]};
            default:     k = v;
        endcase
        return k;
    endfunction

endpackage

FILE: hw/rtl/tvs_in_if.sv
interface tvs_in_if import tvs_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/tvs_out_if.sv
interface tvs_out_if import tvs_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/typed_vector_sort.sv
// Load: one element per cycle into a 64-entry store (one write and one read a cycle).
// Sort: selection by repeated sweeps; each sweep reads every loaded entry and the
// entry with the smallest unused key is then emitted, so a run of n elements takes
// n sweeps after the final element, plus any waits of the output register for o_out.ready.
// Emitted entries are marked in a used-bit vector; the RAM is read once per cycle.
// Reset (i_rst_n low, synchronous) clears count, flags and state; type reverts
// to signed 32-bit integer. Store contents are undefined until written.
module typed_vector_sort import tvs_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_wdata,
    tvs_in_if.sink          i_in,
    tvs_out_if.source       o_out
);

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_EMIT  = 3'b100
    } t_state;

    logic [63:0]      r_mem [MaxLen];
    logic [63:0]      r_rdata;
    t_state           r_state;
    t_elem_type       r_type;
    logic [CntW-1:0]  r_count;
    logic             r_ovf;
    logic [MaxLen-1:0] r_used;
    logic [CntW-1:0]  r_scan;     // address issued
    logic             r_rd_vld;
    logic [IdxW-1:0]  r_rd_idx;
    logic             r_best_vld;
    logic [63:0]      r_best_key;
    logic [63:0]      r_best_val;
    logic [IdxW-1:0]  r_best_idx;
    logic [CntW-1:0]  r_left;
    logic             r_ovalid;
    t_out_item        r_odata;

    logic        in_acc;
    logic [63:0] cand_val;
    logic [63:0] cand_key;
    logic        take;
    logic        emit_go;

    assign i_in.ready = (r_state == ST_LOAD);
    assign in_acc     = i_in.valid && i_in.ready;
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_odata;

    assign cand_val = norm_value(r_rdata, r_type);
    assign cand_key = order_key(cand_val, r_type);
    assign take = r_rd_vld && !r_used[r_rd_idx] &&
                  (!r_best_vld || cand_key < r_best_key);
    assign emit_go = (r_state == ST_EMIT) && (!r_ovalid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (in_acc && r_count < CntW'(MaxLen)) begin
            r_mem[r_count[IdxW-1:0]] <= i_in.data.element_value;
        end
        r_rdata <= r_mem[r_scan[IdxW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_type     <= TYPE_INT32;
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_used     <= '0;
            r_scan     <= '0;
            r_rd_vld   <= 1'b0;
            r_rd_idx   <= '0;
            r_best_vld <= 1'b0;
            r_left     <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_type <= t_elem_type'(i_cfg_wdata);
            end
            if (emit_go) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_LOAD: begin
                    if (in_acc) begin
                        if (r_count < CntW'(MaxLen)) begin
                            r_count <= r_count + 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_in.data.is_final) begin
                            r_left     <= (r_count < CntW'(MaxLen)) ?
                                          r_count + 1'b1 : r_count;
                            r_used     <= '0;
                            r_scan     <= '0;
                            r_rd_vld   <= 1'b0;
                            r_best_vld <= 1'b0;
                            r_state    <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    // issue reads 0..count-1, compare each in the cycle after its read
                    r_rd_vld <= (r_scan < r_count);
                    r_rd_idx <= r_scan[IdxW-1:0];
                    if (r_scan < r_count) begin
                        r_scan <= r_scan + 1'b1;
                    end
                    if (take) begin
                        r_best_vld <= 1'b1;
                        r_best_key <= cand_key;
                        r_best_val <= cand_val;
                        r_best_idx <= r_rd_idx;
                    end
                    if (!r_rd_vld && r_scan == r_count) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    // hold until the output register is free
                    if (emit_go) begin
                        r_odata.sorted_value    <= r_best_val;
                        r_odata.end_of_run      <= (r_left == CntW'(1));
                        r_odata.overflowed      <= r_ovf;
                        r_used[r_best_idx]      <= 1'b1;
                        r_left                  <= r_left - 1'b1;
                        r_best_vld              <= 1'b0;
                        r_scan                  <= '0;
                        r_rd_vld                <= 1'b0;
                        if (r_left == CntW'(1)) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= ST_LOAD;
                        end else begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import tvs_pkg::*;

    localparam int CycleLimit = 800000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_wdata = TYPE_INT32;

    tvs_in_if  in_ch();
    tvs_out_if out_ch();

    typed_vector_sort uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
    end

    t_in_item    pend_q[$];
    t_out_item   sorted_q[$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          err_cnt = 0;
    int unsigned cycle_cnt = 0;

    // Shadow of the element type register and of the loading store
    t_elem_type  cur_type = TYPE_INT32;
    logic [63:0] raw_store[MaxLen];
    int          held_cnt = 0;
    logic        dropped = 1'b0;

    // Build the ascending run from the held raw elements
    task automatic sort_held_run();
        logic [63:0] keys[MaxLen];
        logic [63:0] vals[MaxLen];
        logic [63:0] v, k;
        t_out_item   res;
        int          j;
        for (int i = 0; i < held_cnt; i++) begin
            case (cur_type)
                TYPE_BOOL:  v = {63'd0, |raw_store[i]};
                TYPE_PIXEL: v = {56'd0, raw_store[i][7:0]};
                TYPE_INT32: v = {32'd0, raw_store[i][31:0]};
                default:    v = raw_store[i];
            endcase
            case (cur_type)
                TYPE_INT32:  k = {32'd0, ~v[31], v[30:0]};
                TYPE_DOUBLE: k = v[63] ? ~v : {1'b1, v[62:0]};
                default:     k = v;
            endcase
            j = i;
            while (j > 0 && keys[j-1] > k) begin
                keys[j] = keys[j-1];
                vals[j] = vals[j-1];
                j--;
            end
            keys[j] = k;
            vals[j] = v;
        end
        for (int i = 0; i < held_cnt; i++) begin
            res.sorted_value = vals[i];
            res.end_of_run   = (i == held_cnt - 1);
            res.overflowed   = dropped;
            sorted_q.push_back(res);
        end
        held_cnt = 0;
        dropped  = 1'b0;
    endtask

    // Driver: hold the transaction until taken, idle at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid  <= 1'b0;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (!in_ch.valid || in_ch.ready) begin
                if (pend_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_ch.valid <= 1'b1;
                    in_ch.data  <= pend_q.pop_front();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: predict on input transactions, check output transactions
    always @(posedge i_clk) begin
        t_out_item want;
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CycleLimit) begin
            $display("tb_top: done, errors");
            $finish;
        end else if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                if (held_cnt < MaxLen) begin
                    raw_store[held_cnt] = in_ch.data.element_value;
                    held_cnt++;
                end else begin
                    dropped = 1'b1;
                end
                if (in_ch.data.is_final)
                    sort_held_run();
            end
            if (out_ch.valid && out_ch.ready) begin
                if (sorted_q.size() == 0) begin
                    $error("unexpected result %h", out_ch.data.sorted_value);
                    err_cnt++;
                end else begin
                    want = sorted_q.pop_front();
                    if (out_ch.data.sorted_value !== want.sorted_value) begin
                        $error("sorted_value: expected %h, got %h",
                               want.sorted_value, out_ch.data.sorted_value);
                        err_cnt++;
                    end
                    if (out_ch.data.end_of_run !== want.end_of_run) begin
                        $error("end_of_run: expected %b, got %b",
                               want.end_of_run, out_ch.data.end_of_run);
                        err_cnt++;
                    end
                    if (out_ch.data.overflowed !== want.overflowed) begin
                        $error("overflowed: expected %b, got %b",
                               want.overflowed, out_ch.data.overflowed);
                        err_cnt++;
                    end
                end
            end
        end
    end

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pend_q.size() != 0 || in_ch.valid || sorted_q.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_type(t_elem_type ty);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= ty;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        cur_type = ty;
    endtask

    function automatic void push_elem(logic [63:0] v, logic fin);
        t_in_item it;
        it.element_value = v;
        it.is_final      = fin;
        pend_q.push_back(it);
    endfunction

    function automatic logic [63:0] pick_value();
        logic [63:0] specials[10] = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
            64'h8000_0000_0000_0000, 64'h7FF8_0000_0000_0000, 64'hFFF8_0000_0000_0001,
            64'h7FF0_0000_0000_0000, 64'h0000_0000_8000_0000, 64'h0000_0000_7FFF_FFFF,
            64'h3FF0_0000_0000_0000, 64'h0000_0000_0000_00FF};
        case ($urandom_range(0, 5))
            0:       return {$urandom, $urandom};
            1:       return 64'($urandom_range(0, 3));
            2:       return specials[$urandom_range(0, 9)];
            3:       return {32'($urandom), 32'($signed($urandom_range(0, 200)) - 100)};
            4:       return {$urandom_range(0, 1) ? 32'hC000_0000 : 32'h4000_0000, $urandom};
            default: return {$urandom, $urandom} & 64'h8000_0000_FFFF_FFFF;
        endcase
    endfunction

    // Queue one vector; final flag on its last element
    function automatic void push_vector(int len);
        for (int i = 0; i < len; i++)
            push_elem(pick_value(), i == len - 1);
    endfunction

    int sent;
    int len;

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 21;
        recv_idle_pct = 58;

        // Directed: extremes per type, a single-element run, total order of doubles
        write_type(TYPE_INT32);
        push_elem(64'h0000_0000_7FFF_FFFF, 1'b0);
        push_elem(64'hFFFF_FFFF_8000_0000, 1'b0);
        push_elem(64'h0, 1'b0);
        push_elem(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        push_elem(64'h1234_5678_9ABC_DEF0, 1'b1);
        wait_idle();
        write_type(TYPE_DOUBLE);
        push_elem(64'h0000_0000_0000_0000, 1'b0);
        push_elem(64'h8000_0000_0000_0000, 1'b0);
        push_elem(64'h7FF8_0000_0000_0000, 1'b0);
        push_elem(64'hFFF8_0000_0000_0000, 1'b0);
        push_elem(64'hFFF0_0000_0000_0000, 1'b0);
        push_elem(64'h7FF0_0000_0000_0000, 1'b1);
        wait_idle();
        write_type(TYPE_BOOL);
        push_elem(64'h8000_0000_0000_0000, 1'b0);
        push_elem(64'h0, 1'b0);
        push_elem(64'h1, 1'b1);
        wait_idle();
        write_type(TYPE_PIXEL);
        push_elem(64'hFFFF_FFFF_FFFF_FF00, 1'b0);
        push_elem(64'h0000_0000_0000_00FF, 1'b0);
        push_elem(64'h0000_0000_0000_0080, 1'b1);
        wait_idle();

        // Change type part-way through loading; the final-step type rules the run
        push_elem(64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
        push_elem(64'h0000_0000_0000_0005, 1'b0);
        wait_idle();
        write_type(TYPE_INT32);
        push_elem(64'h0000_0000_0000_0003, 1'b1);
        wait_idle();

        // Full store, overflow on a plain element, then a dropped final element
        for (int i = 0; i < MaxLen + 2; i++)
            push_elem(pick_value(), i == MaxLen + 1);
        wait_idle();
        write_type(TYPE_DOUBLE);
        for (int i = 0; i < MaxLen + 1; i++)
            push_elem(pick_value(), i == MaxLen);
        wait_idle();
        push_vector(MaxLen);
        wait_idle();

        // Random: three idling modes, type changed between batches
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 21 : (mode == 1) ? 58 : 0;
            recv_idle_pct = (mode == 0) ? 58 : (mode == 1) ? 21 : 0;
            sent = 0;
            while (sent < 36) begin
                write_type(t_elem_type'($urandom_range(0, 3)));
                for (int b = 0; b < 4; b++) begin
                    len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, MaxLen + 3)
                                                       : $urandom_range(1, 8);
                    push_vector(len);
                    sent += len;
                end
                wait_idle();
            end
        end

        wait_idle();
        repeat (50) @(posedge i_clk);
        if (err_cnt == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
